FILE: hdl/rgst_pkg.sv
// shared constants, types and state encodings of the range gcd segment tree
`timescale 1ns / 1ps
package rgst_pkg;

  // tree geometry
  localparam int LEAVES = 1024;
  localparam int DEPTH  = 2 * LEAVES;
  localparam int NODE_W = $clog2(DEPTH);

  // item field widths
  localparam int IDX_W = 10;
  localparam int VAL_W = 31;

  // width of the common power-of-two count in the gcd unit
  localparam int K_W = $clog2(VAL_W);

  // opcodes
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // main sequencer
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_RDL,
    ST_UPD_RDR,
    ST_UPD_GO,
    ST_UPD_WAIT,
    ST_Q_CHECK,
    ST_Q_LGO,
    ST_Q_LWAIT,
    ST_Q_RCHK,
    ST_Q_RGO,
    ST_Q_RWAIT,
    ST_Q_STEP
  } state_t;

  // gcd unit
  typedef enum logic [1:0] {
    G_IDLE,
    G_TWOS,
    G_RUN
  } gcd_state_t;

endpackage

FILE: hdl/rgst_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module rgst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rgst_gcd.sv
// iterative binary gcd unit, one shift or subtract per cycle
`timescale 1ns / 1ps
module rgst_gcd import rgst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] a_in,
  input  logic [VAL_W-1:0] b_in,
  output logic             done,
  output logic [VAL_W-1:0] result
);

  gcd_state_t       state, state_next;
  logic [VAL_W-1:0] a, b;
  logic [K_W-1:0]   k;
  logic             a_gt_b;

  assign a_gt_b = a > b;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      G_IDLE: begin
        if (start) begin
          if (a_in == '0 || b_in == '0) begin
            state_next = G_RUN;
          end else begin
            state_next = G_TWOS;
          end
        end
      end
      G_TWOS: begin
        if (a[0] || b[0]) begin
          state_next = G_RUN;
        end
      end
      G_RUN: begin
        if (b == '0) begin
          state_next = G_IDLE;
        end
      end
      default: state_next = G_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done   = (state == G_RUN) && (b == '0);
    result = VAL_W'(a << k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    case (state)
      G_IDLE: begin
        if (start) begin
          k <= '0;
          if (a_in == '0 || b_in == '0) begin
            // gcd with zero is the other operand
            a <= a_in | b_in;
            b <= '0;
          end else begin
            a <= a_in;
            b <= b_in;
          end
        end
      end
      G_TWOS: begin
        if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + K_W'(1);
        end
      end
      G_RUN: begin
        if (b != '0) begin
          if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (a_gt_b) begin
            a <= b;
            b <= a - b;
          end else begin
            b <= b - a;
          end
        end
      end
      default: begin
        k <= '0;
      end
    endcase
  end

endmodule

FILE: hdl/range_gcd_segment_tree.sv
// top level of the range gcd segment tree: sequencer, node memory and gcd unit
`timescale 1ns / 1ps
// Range GCD segment tree over 1024 leaves of 31-bit values. Raise start with an
// item while busy is low; the item is taken at that clock edge. An update item
// (opcode 1) writes one leaf and recomputes every ancestor up to the root; it
// gives no result. A query item (opcode 0) returns the gcd of leaves
// first_index..last_index on range_gcd, valid for exactly one cycle while done
// is high; the receiver cannot stall it, so it must capture it then. An empty
// range gives 0, and last_index is clipped to the top leaf. After reset the
// block clears its 2048-entry node memory one entry per cycle, with busy high
// until the sweep is over. Every item is worked on alone, busy staying high
// until it is finished. All gcd work goes through one shared binary gcd unit
// (one shift or subtract per cycle). An update writes the leaf and then, for
// each of the 10 tree levels, reads both children from memory and runs one
// gcd; a query runs up to two gcds per level, plus memory reads and
// bookkeeping. A query with an empty range is answered at once, without
// raising busy.
module range_gcd_segment_tree import rgst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             opcode,
  input  logic [IDX_W-1:0] first_index,
  input  logic [IDX_W-1:0] last_index,
  input  logic [VAL_W-1:0] new_value,
  output logic             done,
  output logic [VAL_W-1:0] range_gcd
);

  state_t state, state_next;

  // sequencer registers
  logic [NODE_W-1:0] clr_addr;   // clearing sweep pointer
  logic [NODE_W-1:0] p;          // current node of an update walk
  logic [NODE_W:0]   l, r;       // query bounds, one bit wider for l+1
  logic [VAL_W-1:0]  acc;        // running query gcd
  logic [VAL_W-1:0]  opa;        // left child of an update level
  logic [VAL_W-1:0]  val;        // leaf value of an update

  // node memory ports
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic [NODE_W-1:0] mem_raddr;
  logic [VAL_W-1:0]  mem_rdata;

  // gcd unit ports
  logic              gcd_start;
  logic [VAL_W-1:0]  gcd_a, gcd_b;
  logic              gcd_done;
  logic [VAL_W-1:0]  gcd_result;

  // input decode
  logic              accept;
  logic              upd_in_range;
  logic [IDX_W-1:0]  last_sat;
  logic              q_empty;
  logic              clr_last;

  assign accept       = start && (state == ST_IDLE);
  assign upd_in_range = 32'(first_index) < LEAVES;
  // an out-of-range right end is clipped to the top leaf
  assign last_sat     = (32'(last_index) >= LEAVES) ? IDX_W'(LEAVES - 1) : last_index;
  assign q_empty      = 32'(first_index) > 32'(last_sat);
  assign clr_last     = clr_addr == NODE_W'(DEPTH - 1);

  assign busy = state != ST_IDLE;

  rgst_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_nodes (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  rgst_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a_in  (gcd_a),
    .b_in  (gcd_b),
    .done  (gcd_done),
    .result(gcd_result)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_UPDATE) begin
            // an update beyond the last leaf is dropped
            if (upd_in_range) begin
              state_next = ST_UPD_LEAF;
            end
          end else if (!q_empty) begin
            state_next = ST_Q_CHECK;
          end
        end
      end
      ST_UPD_LEAF: state_next = ST_UPD_RDL;
      ST_UPD_RDL:  state_next = ST_UPD_RDR;
      ST_UPD_RDR:  state_next = ST_UPD_GO;
      ST_UPD_GO:   state_next = ST_UPD_WAIT;
      ST_UPD_WAIT: begin
        if (gcd_done) begin
          // root written, walk is over
          if (p == NODE_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_UPD_RDL;
          end
        end
      end
      ST_Q_CHECK: begin
        if (l > r) begin
          state_next = ST_IDLE;
        end else if (l[0]) begin
          state_next = ST_Q_LGO;
        end else begin
          state_next = ST_Q_RCHK;
        end
      end
      ST_Q_LGO: state_next = ST_Q_LWAIT;
      ST_Q_LWAIT: begin
        if (gcd_done) begin
          state_next = ST_Q_RCHK;
        end
      end
      ST_Q_RCHK: begin
        if (!r[0]) begin
          state_next = ST_Q_RGO;
        end else begin
          state_next = ST_Q_STEP;
        end
      end
      ST_Q_RGO: state_next = ST_Q_RWAIT;
      ST_Q_RWAIT: begin
        if (gcd_done) begin
          state_next = ST_Q_STEP;
        end
      end
      ST_Q_STEP: state_next = ST_Q_CHECK;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // memory and gcd unit controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p;
    mem_wdata = gcd_result;
    mem_raddr = l[NODE_W-1:0];
    gcd_start = 1'b0;
    gcd_a     = acc;
    gcd_b     = mem_rdata;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_UPD_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = val;
      end
      // children of p sit at 2p and 2p+1
      ST_UPD_RDL: mem_raddr = {p[NODE_W-2:0], 1'b0};
      ST_UPD_RDR: mem_raddr = {p[NODE_W-2:0], 1'b1};
      ST_UPD_GO: begin
        gcd_start = 1'b1;
        gcd_a     = opa;
      end
      ST_UPD_WAIT: mem_we = gcd_done;
      ST_Q_CHECK:  mem_raddr = l[NODE_W-1:0];
      ST_Q_LGO:    gcd_start = 1'b1;
      ST_Q_RCHK:   mem_raddr = r[NODE_W-1:0];
      ST_Q_RGO:    gcd_start = 1'b1;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + NODE_W'(1);
      end
      if (state == ST_IDLE && accept && opcode == OP_QUERY && q_empty) begin
        done <= 1'b1;
      end
      if (state == ST_Q_CHECK && l > r) begin
        done <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          p   <= NODE_W'(LEAVES) + NODE_W'(first_index);
          val <= new_value;
          l   <= (NODE_W + 1)'(LEAVES) + (NODE_W + 1)'(first_index);
          r   <= (NODE_W + 1)'(LEAVES) + (NODE_W + 1)'(last_sat);
          acc <= '0;
          if (opcode == OP_QUERY && q_empty) begin
            range_gcd <= '0;
          end
        end
      end
      ST_UPD_LEAF: p <= p >> 1;
      ST_UPD_RDR:  opa <= mem_rdata;
      ST_UPD_WAIT: begin
        if (gcd_done) begin
          p <= p >> 1;
        end
      end
      ST_Q_CHECK: begin
        if (l > r) begin
          range_gcd <= acc;
        end
      end
      ST_Q_LWAIT, ST_Q_RWAIT: begin
        if (gcd_done) begin
          acc <= gcd_result;
        end
      end
      ST_Q_STEP: begin
        l <= (l + (NODE_W + 1)'(1)) >> 1;
        r <= (r - (NODE_W + 1)'(1)) >> 1;
      end
      default: begin
        opa <= opa;
      end
    endcase
  end

endmodule

FILE: hdl/rgst_checker.sv
// port-level checks of the range gcd segment tree and their binding
`timescale 1ns / 1ps
module rgst_checker import rgst_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic opcode,
  input logic done
);

  // reset starts the clearing sweep and drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("reset did not start the clearing sweep");

  // a result only shows once its item is finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // an update never produces a result
  a_update_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_UPDATE |=> !done)
    else $error("update item produced a result");

  // a query either answers at once or keeps the block busy
  a_query_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_QUERY |=> done || busy)
    else $error("query item was lost");

endmodule

bind range_gcd_segment_tree rgst_checker u_rgst_checker (.*);
